// ----- design/odo_pkg.sv -----
// shared constants, state types and the arctangent table for the odometry block
// no dependencies
`timescale 1ns / 1ps

package odo_pkg;

    // rotation steps of the cordic
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // bit-serial multiplier sizes
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = 5;
    localparam int KINV_W    = 24;
    localparam logic [KINV_W-1:0] KINV_Q24 = 24'd10188014;

    // datapath widths
    localparam int SUM_W = 18;   // dr + dl
    localparam int DIF_W = 17;   // dr - dl
    localparam int PW    = 50;   // (dr + dl) * dist_per_tick
    localparam int DCW   = PW - 9;
    localparam int KW    = 42;   // gain-corrected travel
    localparam int XW    = 44;   // cordic x and y
    localparam int ZW    = 34;   // cordic residual angle

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCALE,
        ST_TURN,
        ST_ROT,
        ST_WB
    } odo_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_GAIN
    } odo_sc_phase_t;

    typedef enum logic {
        CR_IDLE,
        CR_RUN
    } odo_cr_phase_t;

    // floor(atan(2^-i) * 2^32 / (2 pi))
    function automatic logic [31:0] atan_turns(input int unsigned i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;  1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;  3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;  9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;  11: a = 32'h000517CC;
            12: a = 32'h00028BE6;  13: a = 32'h000145F3;
            14: a = 32'h0000A2F9;  15: a = 32'h0000517C;
            16: a = 32'h000028BE;  17: a = 32'h0000145F;
            18: a = 32'h00000A2F;  19: a = 32'h00000517;
            20: a = 32'h0000028B;  21: a = 32'h00000145;
            22: a = 32'h000000A2;  23: a = 32'h00000051;
            24: a = 32'h00000028;  25: a = 32'h00000014;
            26: a = 32'h0000000A;  27: a = 32'h00000005;
            28: a = 32'h00000002;  29: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ----- design/odo_scale.sv -----
// bit-serial scaling: travel and heading products, then cordic gain correction
// depends on odo_pkg
`timescale 1ns / 1ps

module odo_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [odo_pkg::SUM_W-1:0] tick_sum,
    input  logic signed [odo_pkg::DIF_W-1:0] tick_diff,
    input  logic [31:0]                   dist_per_tick,
    input  logic [31:0]                   heading_per_tick,
    output logic [odo_pkg::XW-1:0]        travel,
    output logic [31:0]                   heading_delta,
    output logic                          done
);

    odo_pkg::odo_sc_phase_t phase_reg, phase_next;
    logic [odo_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [odo_pkg::PW-1:0]    acc_reg, acc_next, mc_reg, mc_next;
    logic [31:0]               mp_reg, mp_next;
    logic [31:0]               hacc_reg, hacc_next, hmc_reg, hmc_next, hmp_reg, hmp_next;
    logic [odo_pkg::KW-1:0]    kacc_reg, kacc_next;
    logic                      done_reg, done_next;
    logic [odo_pkg::DCW-1:0]   dc;
    logic [odo_pkg::KW:0]      ksum;

    // mean travel in q.24 and one gain bit per cycle, lsb first
    assign dc   = acc_reg[odo_pkg::PW-1:9];
    assign ksum = {kacc_reg[odo_pkg::KW-1], kacc_reg}
                + (odo_pkg::KINV_Q24[cnt_reg]
                   ? {{(odo_pkg::KW+1-odo_pkg::DCW){dc[odo_pkg::DCW-1]}}, dc}
                   : '0);

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            odo_pkg::SC_IDLE: begin
                if (start) phase_next = odo_pkg::SC_MUL;
            end
            odo_pkg::SC_MUL: begin
                if (cnt_reg == odo_pkg::CNT_W'(odo_pkg::MUL_STEPS-1))
                    phase_next = odo_pkg::SC_GAIN;
            end
            odo_pkg::SC_GAIN: begin
                if (cnt_reg == odo_pkg::CNT_W'(odo_pkg::KINV_W-1))
                    phase_next = odo_pkg::SC_IDLE;
            end
            default: phase_next = odo_pkg::SC_IDLE;
        endcase
    end

    // shift-and-add datapath
    always_comb begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        hacc_next = hacc_reg;
        hmc_next  = hmc_reg;
        hmp_next  = hmp_reg;
        kacc_next = kacc_reg;
        done_next = 1'b0;
        unique case (phase_reg)
            odo_pkg::SC_IDLE: begin
                if (start) begin
                    cnt_next  = '0;
                    acc_next  = '0;
                    mc_next   = odo_pkg::PW'(tick_sum);
                    mp_next   = dist_per_tick;
                    hacc_next = '0;
                    hmc_next  = 32'(tick_diff);
                    hmp_next  = heading_per_tick;
                    kacc_next = '0;
                end
            end
            odo_pkg::SC_MUL: begin
                if (mp_reg[0]) acc_next = acc_reg + mc_reg;
                if (hmp_reg[0]) hacc_next = hacc_reg + hmc_reg;
                mc_next  = {mc_reg[odo_pkg::PW-2:0], 1'b0};
                hmc_next = {hmc_reg[30:0], 1'b0};
                mp_next  = {1'b0, mp_reg[31:1]};
                hmp_next = {1'b0, hmp_reg[31:1]};
                if (cnt_reg == odo_pkg::CNT_W'(odo_pkg::MUL_STEPS-1)) cnt_next = '0;
                else cnt_next = cnt_reg + 1'b1;
            end
            odo_pkg::SC_GAIN: begin
                kacc_next = ksum[odo_pkg::KW:1];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == odo_pkg::CNT_W'(odo_pkg::KINV_W-1)) done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= odo_pkg::SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        mc_reg   <= mc_next;
        mp_reg   <= mp_next;
        hacc_reg <= hacc_next;
        hmc_reg  <= hmc_next;
        hmp_reg  <= hmp_next;
        kacc_reg <= kacc_next;
    end

    assign travel        = {{(odo_pkg::XW-odo_pkg::KW){kacc_reg[odo_pkg::KW-1]}}, kacc_reg};
    assign heading_delta = hacc_reg;
    assign done          = done_reg;

endmodule

// ----- design/odo_cordic.sv -----
// iterative rotation cordic, one micro-rotation per cycle
// depends on odo_pkg
`timescale 1ns / 1ps

module odo_cordic (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [odo_pkg::XW-1:0] travel,
    input  logic [31:0]            heading,
    output logic [31:0]            dx,
    output logic [31:0]            dy,
    output logic                   done
);

    odo_pkg::odo_cr_phase_t phase_reg, phase_next;
    logic [odo_pkg::STEP_W-1:0] step_reg, step_next;
    logic signed [odo_pkg::XW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [odo_pkg::ZW-1:0] z_reg, z_next, ang;
    logic                          fold;
    logic [31:0]                   t_fold;
    logic                          done_reg, done_next;
    logic [odo_pkg::XW-1:0]        xr, yr;

    // fold headings in the back half-plane by half a turn
    assign fold   = (heading[31:30] == 2'b01) || (heading[31:30] == 2'b10);
    assign t_fold = fold ? (heading ^ 32'h8000_0000) : heading;
    assign xs     = x_reg >>> step_reg;
    assign ys     = y_reg >>> step_reg;
    assign ang    = odo_pkg::ZW'(odo_pkg::atan_turns(int'(step_reg)));

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            odo_pkg::CR_IDLE: if (start) phase_next = odo_pkg::CR_RUN;
            odo_pkg::CR_RUN: begin
                if (step_reg == odo_pkg::STEP_W'(odo_pkg::CORDIC_STEPS-1))
                    phase_next = odo_pkg::CR_IDLE;
            end
            default: phase_next = odo_pkg::CR_IDLE;
        endcase
    end

    // micro-rotation datapath
    always_comb begin
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        unique case (phase_reg)
            odo_pkg::CR_IDLE: begin
                if (start) begin
                    step_next = '0;
                    x_next    = fold ? -$signed(travel) : $signed(travel);
                    y_next    = '0;
                    z_next    = odo_pkg::ZW'($signed(t_fold));
                end
            end
            odo_pkg::CR_RUN: begin
                if (!z_reg[odo_pkg::ZW-1]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - ang;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + ang;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == odo_pkg::STEP_W'(odo_pkg::CORDIC_STEPS-1)) done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= odo_pkg::CR_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // q.24 to q16.16, rounded half up
    assign xr   = x_reg + odo_pkg::XW'(128);
    assign yr   = y_reg + odo_pkg::XW'(128);
    assign dx   = xr[39:8];
    assign dy   = yr[39:8];
    assign done = done_reg;

endmodule

// ----- design/differential_drive_odometry.sv -----
// top level of the differential-drive odometry block
// depends on odo_pkg, odo_scale and odo_cordic
`timescale 1ns / 1ps

// Dead-reckoning pose tracker. Each transfer on the s_ stream carries the
// absolute right and left encoder counts; each produces exactly one transfer
// on the m_ stream with the updated pose (x, y in Q16.16 metres, heading in
// 2^-32 turn). The APB port sets the distance and heading scale per tick.
// Each sample passes through a load step, the bit-serial travel and heading
// multipliers, the serial gain correction, the CORDIC_STEPS micro-rotations
// of the rotation stage, and the handoff between the stages and the pose
// update. The block takes one sample at a time; s_tready rises in the same
// cycle as m_tvalid when the result appears. s_tready is high only when the
// block is idle. The result stays on m_tdata with m_tvalid high until taken;
// a stalled receiver holds the next pose update back, but the following
// sample is still accepted and computed meanwhile. Reset clears the pose,
// the stored encoder counts and restores the default scale registers.
module differential_drive_odometry (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // right_position[15:0], left_position[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pose_x[31:0], pose_y[63:32], pose_heading[95:64]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    odo_pkg::odo_state_t state_reg, state_next;
    logic [31:0] dpt_reg, dpt_next, hpt_reg, hpt_next;
    logic [15:0] last_r_reg, last_r_next, last_l_reg, last_l_next;
    logic [31:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next, acc_h_reg, acc_h_next;
    logic signed [odo_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [odo_pkg::DIF_W-1:0] dif_reg, dif_next;
    logic        mvalid_reg, mvalid_next;
    logic        s_fire, cfg_wr, out_free;
    logic [15:0] dr16, dl16;
    logic        scale_start, scale_done, rot_start, rot_done;
    logic [odo_pkg::XW-1:0] travel;
    logic [31:0] hdelta, dx, dy;

    assign s_fire   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !mvalid_reg || m_tready;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? hpt_reg : dpt_reg;

    // configuration writes
    always_comb begin
        dpt_next = dpt_reg;
        hpt_next = hpt_reg;
        if (cfg_wr) begin
            if (paddr[2]) hpt_next = pwdata;
            else dpt_next = pwdata;
        end
    end

    // wrapped tick deltas
    assign dr16 = s_tdata[15:0] - last_r_reg;
    assign dl16 = s_tdata[31:16] - last_l_reg;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            odo_pkg::ST_IDLE:  if (s_fire) state_next = odo_pkg::ST_LOAD;
            odo_pkg::ST_LOAD:  state_next = odo_pkg::ST_SCALE;
            odo_pkg::ST_SCALE: if (scale_done) state_next = odo_pkg::ST_TURN;
            odo_pkg::ST_TURN:  state_next = odo_pkg::ST_ROT;
            odo_pkg::ST_ROT:   if (rot_done) state_next = odo_pkg::ST_WB;
            odo_pkg::ST_WB:    if (out_free) state_next = odo_pkg::ST_IDLE;
            default:           state_next = odo_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready    = 1'b0;
        scale_start = 1'b0;
        rot_start   = 1'b0;
        unique case (state_reg)
            odo_pkg::ST_IDLE: s_tready    = 1'b1;
            odo_pkg::ST_LOAD: scale_start = 1'b1;
            odo_pkg::ST_TURN: rot_start   = 1'b1;
            default: ;
        endcase
    end

    // sample capture, pose update and result transfer
    always_comb begin
        last_r_next = last_r_reg;
        last_l_next = last_l_reg;
        sum_next    = sum_reg;
        dif_next    = dif_reg;
        acc_x_next  = acc_x_reg;
        acc_y_next  = acc_y_reg;
        acc_h_next  = acc_h_reg;
        mvalid_next = mvalid_reg && !m_tready;
        if (s_fire) begin
            last_r_next = s_tdata[15:0];
            last_l_next = s_tdata[31:16];
            sum_next    = odo_pkg::SUM_W'($signed(dr16)) + odo_pkg::SUM_W'($signed(dl16));
            dif_next    = odo_pkg::DIF_W'($signed(dr16)) - odo_pkg::DIF_W'($signed(dl16));
        end
        if (state_reg == odo_pkg::ST_WB && out_free) begin
            acc_x_next  = acc_x_reg + dx;
            acc_y_next  = acc_y_reg + dy;
            acc_h_next  = acc_h_reg + hdelta;
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= odo_pkg::ST_IDLE;
            dpt_reg    <= 32'd2428743;
            hpt_reg    <= 32'd2089450;
            last_r_reg <= '0;
            last_l_reg <= '0;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
            acc_h_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            dpt_reg    <= dpt_next;
            hpt_reg    <= hpt_next;
            last_r_reg <= last_r_next;
            last_l_reg <= last_l_next;
            acc_x_reg  <= acc_x_next;
            acc_y_reg  <= acc_y_next;
            acc_h_reg  <= acc_h_next;
            mvalid_reg <= mvalid_next;
        end
        sum_reg <= sum_next;
        dif_reg <= dif_next;
    end

    odo_scale u_scale (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (scale_start),
        .tick_sum         (sum_reg),
        .tick_diff        (dif_reg),
        .dist_per_tick    (dpt_reg),
        .heading_per_tick (hpt_reg),
        .travel           (travel),
        .heading_delta    (hdelta),
        .done             (scale_done)
    );

    // rotation uses the heading from before this sample
    odo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rot_start),
        .travel  (travel),
        .heading (acc_h_reg),
        .dx      (dx),
        .dy      (dy),
        .done    (rot_done)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {acc_h_reg, acc_y_reg, acc_x_reg};

    // checks
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == odo_pkg::ST_LOAD)
        else $error("accepted sample did not start processing");

    a_scale_done: assert property (@(posedge aclk) disable iff (!aresetn)
        scale_done |-> state_reg == odo_pkg::ST_SCALE)
        else $error("scale finished outside its phase");

    a_rot_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rot_done |-> state_reg == odo_pkg::ST_ROT)
        else $error("rotation finished outside its phase");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == odo_pkg::ST_WB))
        else $error("result raised without a pose update");

endmodule
